FILE: rtl/clex_pkg.sv
// Shared types, constants and helper functions for the C subset lexer.
// No dependencies; compiled before every other file of the block.
package clex_pkg;

    localparam int POSITION_WIDTH = 24;
    localparam int LENGTH_WIDTH   = 16;
    localparam int KEYWORD_CHARS  = 6;

    localparam int LINE_W  = 24;
    localparam int VALUE_W = 31;
    localparam int KIND_W  = 5;
    localparam int PFX_IDX_W = $clog2(KEYWORD_CHARS);

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 31'h7FFF_FFFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_NUL = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        K_EOF    = 5'd0,
        K_ERROR  = 5'd1,
        K_IDENT  = 5'd2,
        K_NUMBER = 5'd3,
        K_LPAREN = 5'd4,
        K_RPAREN = 5'd5,
        K_LBRACE = 5'd6,
        K_RBRACE = 5'd7,
        K_SEMI   = 5'd8,
        K_COMMA  = 5'd9,
        K_PLUS   = 5'd10,
        K_MINUS  = 5'd11,
        K_STAR   = 5'd12,
        K_SLASH  = 5'd13,
        K_BANG   = 5'd14,
        K_NE     = 5'd15,
        K_ASSIGN = 5'd16,
        K_EQ     = 5'd17,
        K_LT     = 5'd18,
        K_LE     = 5'd19,
        K_GT     = 5'd20,
        K_GE     = 5'd21,
        K_IF     = 5'd22,
        K_ELSE   = 5'd23,
        K_INT    = 5'd24,
        K_WHILE  = 5'd25,
        K_RETURN = 5'd26
    } kind_t;

    typedef enum logic [1:0] {
        OP_BANG    = 2'd0,
        OP_ASSIGN  = 2'd1,
        OP_LESS    = 2'd2,
        OP_GREATER = 2'd3
    } op_t;

    typedef logic [KEYWORD_CHARS-1:0][7:0] prefix_t;

    typedef struct packed {
        kind_t                     kind;
        logic [POSITION_WIDTH-1:0] start;
        logic [LENGTH_WIDTH-1:0]   length;
        logic [LINE_W-1:0]         line;
        logic [VALUE_W-1:0]        value;
        logic                      last;
    } tok_t;

    // Up to two tokens produced by one byte, oldest in tok0.
    typedef struct packed {
        tok_t       tok0;
        tok_t       tok1;
        logic [1:0] count;
    } emit_t;

    function automatic tok_t make_tok(
        input kind_t                     kind,
        input logic [POSITION_WIDTH-1:0] start,
        input logic [LENGTH_WIDTH-1:0]   length,
        input logic [LINE_W-1:0]         line,
        input logic [VALUE_W-1:0]        value
    );
        tok_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.line   = line;
        t.value  = value;
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    // The stored prefix holds the first characters of the word; only the
    // first len of them are meaningful, and len must match exactly.
    function automatic kind_t word_kind(
        input prefix_t                 p,
        input logic [LENGTH_WIDTH-1:0] len
    );
        kind_t k;
        k = K_IDENT;
        if ((len == LENGTH_WIDTH'(2)) && ({p[0], p[1]} == "if")) begin
            k = K_IF;
        end
        else if ((len == LENGTH_WIDTH'(4)) && ({p[0], p[1], p[2], p[3]} == "else")) begin
            k = K_ELSE;
        end
        else if ((len == LENGTH_WIDTH'(3)) && ({p[0], p[1], p[2]} == "int")) begin
            k = K_INT;
        end
        else if ((len == LENGTH_WIDTH'(5)) &&
                 ({p[0], p[1], p[2], p[3], p[4]} == "while")) begin
            k = K_WHILE;
        end
        else if ((len == LENGTH_WIDTH'(6)) &&
                 ({p[0], p[1], p[2], p[3], p[4], p[5]} == "return")) begin
            k = K_RETURN;
        end
        return k;
    endfunction

    function automatic kind_t op_kind(input op_t op, input logic two);
        kind_t k;
        case (op)
            OP_BANG:   k = two ? K_NE : K_BANG;
            OP_ASSIGN: k = two ? K_EQ : K_ASSIGN;
            OP_LESS:   k = two ? K_LE : K_LT;
            default:   k = two ? K_GE : K_GT;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/clex_step.sv
// Scanner state and the per-byte next-state and token logic of the lexer.
// Depends on clex_pkg for token types, constants and helper functions.
module clex_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           char_code,
    output clex_pkg::emit_t      emit
);
    import clex_pkg::*;

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_WORD    = 6'b000010,
        MODE_NUM     = 6'b000100,
        MODE_SLASH   = 6'b001000,
        MODE_COMMENT = 6'b010000,
        MODE_OP      = 6'b100000
    } mode_t;

    typedef struct packed {
        mode_t                     mode;
        logic [POSITION_WIDTH-1:0] pos;
        logic [POSITION_WIDTH-1:0] begin_pos;
        logic [LENGTH_WIDTH-1:0]   len;
        logic [LINE_W-1:0]         line;
        logic [VALUE_W-1:0]        acc;
        logic                      digits_done;
        op_t                       op;
    } scan_t;

    localparam scan_t SCAN_RESET = '{
        mode:        MODE_IDLE,
        pos:         '0,
        begin_pos:   '0,
        len:         '0,
        line:        LINE_W'(1),
        acc:         '0,
        digits_done: 1'b0,
        op:          OP_BANG
    };

    scan_t   st_reg, st_next;
    prefix_t pfx_reg, pfx_next;

    logic [POSITION_WIDTH-1:0] pos_inc;
    logic [LENGTH_WIDTH-1:0]   len_inc;
    logic [LINE_W-1:0]         line_inc;
    logic [VALUE_W+3:0]        acc_wide;
    logic [VALUE_W-1:0]        acc_step;
    logic                      run_idle;
    logic                      a_hit, b_hit;
    tok_t                      tok_a, tok_b;

    assign pos_inc  = st_reg.pos + POSITION_WIDTH'(1);
    assign len_inc  = (st_reg.len == '1) ? st_reg.len : st_reg.len + LENGTH_WIDTH'(1);
    assign line_inc = (st_reg.line == '1) ? st_reg.line : st_reg.line + LINE_W'(1);

    // acc * 10 + digit as two shifts and adds; saturate beyond the value limit.
    assign acc_wide = ({4'b0, st_reg.acc} << 3) + ({4'b0, st_reg.acc} << 1)
                    + (VALUE_W + 4)'(char_code[3:0] - 4'd0);
    assign acc_step = (acc_wide > {4'b0, VALUE_LIMIT}) ? VALUE_LIMIT : acc_wide[VALUE_W-1:0];

    always_comb
    begin
        st_next  = st_reg;
        pfx_next = pfx_reg;
        run_idle = 1'b0;
        a_hit    = 1'b0;
        b_hit    = 1'b0;
        tok_a    = '0;
        tok_b    = '0;

        // First pass: the pending token, if any, either absorbs the byte or
        // is closed and the byte is then scanned as if between tokens.
        case (st_reg.mode)
            MODE_WORD:
            begin
                if (is_letter(char_code) || is_digit(char_code) || (char_code == "_")) begin
                    if (st_reg.len < LENGTH_WIDTH'(KEYWORD_CHARS)) begin
                        pfx_next[st_reg.len[PFX_IDX_W-1:0]] = char_code;
                    end
                    st_next.len = len_inc;
                    st_next.pos = pos_inc;
                end
                else begin
                    a_hit    = 1'b1;
                    tok_a    = make_tok(word_kind(pfx_reg, st_reg.len), st_reg.begin_pos,
                                        st_reg.len, st_reg.line, '0);
                    run_idle = 1'b1;
                end
            end
            MODE_NUM:
            begin
                if (is_letter(char_code) || is_digit(char_code)) begin
                    if (is_digit(char_code) && !st_reg.digits_done) begin
                        st_next.acc = acc_step;
                    end
                    else begin
                        st_next.digits_done = 1'b1;
                    end
                    st_next.len = len_inc;
                    st_next.pos = pos_inc;
                end
                else begin
                    a_hit    = 1'b1;
                    tok_a    = make_tok(K_NUMBER, st_reg.begin_pos, st_reg.len,
                                        st_reg.line, st_reg.acc);
                    run_idle = 1'b1;
                end
            end
            MODE_SLASH:
            begin
                if (char_code == "/") begin
                    st_next.mode = MODE_COMMENT;
                    st_next.pos  = pos_inc;
                end
                else begin
                    a_hit    = 1'b1;
                    tok_a    = make_tok(K_SLASH, st_reg.begin_pos, LENGTH_WIDTH'(1),
                                        st_reg.line, '0);
                    run_idle = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if ((char_code == CH_NUL) || (char_code == "\n")) begin
                    run_idle = 1'b1;
                end
                else begin
                    st_next.pos = pos_inc;
                end
            end
            MODE_OP:
            begin
                a_hit = 1'b1;
                if (char_code == "=") begin
                    tok_a        = make_tok(op_kind(st_reg.op, 1'b1), st_reg.begin_pos,
                                            LENGTH_WIDTH'(2), st_reg.line, '0);
                    st_next.mode = MODE_IDLE;
                    st_next.pos  = pos_inc;
                end
                else begin
                    tok_a    = make_tok(op_kind(st_reg.op, 1'b0), st_reg.begin_pos,
                                        LENGTH_WIDTH'(1), st_reg.line, '0);
                    run_idle = 1'b1;
                end
            end
            default:
            begin
                run_idle = 1'b1;
            end
        endcase

        // Second pass: the byte seen between tokens. The first pass never
        // moves position or line, so this works from the registered values.
        if (run_idle) begin
            st_next.mode = MODE_IDLE;
            st_next.pos  = pos_inc;
            case (char_code)
                CH_NUL:
                begin
                    b_hit        = 1'b1;
                    tok_b        = make_tok(K_EOF, st_reg.pos, '0, st_reg.line, '0);
                    st_next.pos  = '0;
                    st_next.line = LINE_W'(1);
                end
                " ", "\t", "\r":
                begin
                end
                "\n":
                begin
                    st_next.line = line_inc;
                end
                "/":
                begin
                    st_next.begin_pos = st_reg.pos;
                    st_next.mode      = MODE_SLASH;
                end
                "!", "=", "<", ">":
                begin
                    st_next.begin_pos = st_reg.pos;
                    st_next.mode      = MODE_OP;
                    case (char_code)
                        "!":     st_next.op = OP_BANG;
                        "=":     st_next.op = OP_ASSIGN;
                        "<":     st_next.op = OP_LESS;
                        default: st_next.op = OP_GREATER;
                    endcase
                end
                "(":
                begin
                    b_hit = 1'b1;
                    tok_b = make_tok(K_LPAREN, st_reg.pos, LENGTH_WIDTH'(1), st_reg.line, '0);
                end
                ")":
                begin
                    b_hit = 1'b1;
                    tok_b = make_tok(K_RPAREN, st_reg.pos, LENGTH_WIDTH'(1), st_reg.line, '0);
                end
                "{":
                begin
                    b_hit = 1'b1;
                    tok_b = make_tok(K_LBRACE, st_reg.pos, LENGTH_WIDTH'(1), st_reg.line, '0);
                end
                "}":
                begin
                    b_hit = 1'b1;
                    tok_b = make_tok(K_RBRACE, st_reg.pos, LENGTH_WIDTH'(1), st_reg.line, '0);
                end
                ";":
                begin
                    b_hit = 1'b1;
                    tok_b = make_tok(K_SEMI, st_reg.pos, LENGTH_WIDTH'(1), st_reg.line, '0);
                end
                ",":
                begin
                    b_hit = 1'b1;
                    tok_b = make_tok(K_COMMA, st_reg.pos, LENGTH_WIDTH'(1), st_reg.line, '0);
                end
                "+":
                begin
                    b_hit = 1'b1;
                    tok_b = make_tok(K_PLUS, st_reg.pos, LENGTH_WIDTH'(1), st_reg.line, '0);
                end
                "-":
                begin
                    b_hit = 1'b1;
                    tok_b = make_tok(K_MINUS, st_reg.pos, LENGTH_WIDTH'(1), st_reg.line, '0);
                end
                "*":
                begin
                    b_hit = 1'b1;
                    tok_b = make_tok(K_STAR, st_reg.pos, LENGTH_WIDTH'(1), st_reg.line, '0);
                end
                default:
                begin
                    if (is_letter(char_code) || (char_code == "_")) begin
                        st_next.begin_pos = st_reg.pos;
                        st_next.len       = LENGTH_WIDTH'(1);
                        st_next.mode      = MODE_WORD;
                        pfx_next[0]       = char_code;
                    end
                    else if (is_digit(char_code)) begin
                        st_next.begin_pos   = st_reg.pos;
                        st_next.len         = LENGTH_WIDTH'(1);
                        st_next.acc         = VALUE_W'(char_code[3:0]);
                        st_next.digits_done = 1'b0;
                        st_next.mode        = MODE_NUM;
                    end
                    else begin
                        b_hit = 1'b1;
                        tok_b = make_tok(K_ERROR, st_reg.pos, LENGTH_WIDTH'(1), st_reg.line,
                                         VALUE_W'(char_code));
                    end
                end
            endcase
        end

        emit.count     = {1'b0, a_hit} + {1'b0, b_hit};
        emit.tok0      = a_hit ? tok_a : tok_b;
        emit.tok0.last = !(a_hit && b_hit);
        emit.tok1      = tok_b;
        emit.tok1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= SCAN_RESET;
        end
        else if (fire) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            pfx_reg <= pfx_next;
        end
    end

endmodule

FILE: rtl/clex_fifo.sv
// Small token queue that takes up to two tokens a cycle and gives one.
// Depends on clex_pkg for the token and emit types.
module clex_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  clex_pkg::emit_t                   wr,
    input  logic                              pop,
    output clex_pkg::tok_t                    head,
    output logic [clex_pkg::FIFO_CNT_W-1:0]   count
);
    import clex_pkg::*;

    tok_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wptr_reg, wptr_next;
    logic [FIFO_PTR_W-1:0] rptr_reg, rptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [1:0]            n_wr;

    assign n_wr       = push ? wr.count : 2'd0;
    assign wptr_next  = wptr_reg + FIFO_PTR_W'(n_wr);
    assign rptr_next  = rptr_reg + FIFO_PTR_W'(pop);
    assign count_next = count_reg + FIFO_CNT_W'(n_wr) - FIFO_CNT_W'(pop);

    assign head  = mem_reg[rptr_reg];
    assign count = count_reg;

    always_ff @(posedge clk)
    begin
        if (n_wr != 2'd0) begin
            mem_reg[wptr_reg] <= wr.tok0;
        end
        if (n_wr == 2'd2) begin
            mem_reg[wptr_reg + FIFO_PTR_W'(1)] <= wr.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/c_subset_lexer.sv
// An accepted byte waits in the input register until the token queue has room; it is then
// scanned, and its first token is on the output port once it is written into the queue.
// One byte per cycle in while the queue has room, one token per cycle out while token_stall is low;
// bytes that close a pending token and yield one of their own stall the input once the queue fills.
// Reset (rst_n low, asynchronous): position 0, line 1, scanner between tokens, queue empty.
// Depends on clex_pkg, clex_step and clex_fifo.
module c_subset_lexer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                char_valid,
    output logic                                char_stall,
    input  logic [7:0]                          char_code,
    output logic                                token_valid,
    input  logic                                token_stall,
    output logic [clex_pkg::KIND_W-1:0]         token_kind,
    output logic [clex_pkg::POSITION_WIDTH-1:0] token_start,
    output logic [clex_pkg::LENGTH_WIDTH-1:0]   token_length,
    output logic [clex_pkg::LINE_W-1:0]         line_number,
    output logic [clex_pkg::VALUE_W-1:0]        token_value,
    output logic                                last_of_run
);
    import clex_pkg::*;

    // The input register holds one byte. It is scanned as soon as the token
    // queue has room for the two tokens that a byte can give at most, so the
    // scanner state advances exactly once per accepted item.
    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_char_reg;
    logic                  room;
    logic                  fire;
    logic                  accept;
    logic                  pop;
    emit_t                 emit;
    tok_t                  head;
    logic [FIFO_CNT_W-1:0] q_count;

    assign room       = q_count <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign fire       = in_valid_reg && room;
    assign char_stall = in_valid_reg && !room;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end
        else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            in_char_reg <= char_code;
        end
    end

    // Scanner: the pending-token state and the per-byte decision logic.
    clex_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_code (in_char_reg),
        .emit      (emit)
    );

    // Result queue: tokens leave in order, one per output handshake, and the
    // queue head drives the output ports straight from registers.
    clex_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .wr    (emit),
        .pop   (pop),
        .head  (head),
        .count (q_count)
    );

    assign token_valid  = q_count != '0;
    assign pop          = token_valid && !token_stall;
    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign line_number  = head.line;
    assign token_value  = head.value;
    assign last_of_run  = head.last;

    // The queue never holds more tokens than it has entries.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("token queue count beyond its depth");

    // A scanned byte never yields more than two tokens.
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (emit.count != 2'd3))
        else $error("scanner produced more than two tokens");

    // The queue count follows exactly what was written and taken.
    a_queue_track: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (q_count == $past(q_count)
                          + FIFO_CNT_W'($past(fire) ? $past(emit.count) : 2'd0)
                          - FIFO_CNT_W'($past(pop))))
        else $error("token queue count out of step");

    // End-of-text tokens are empty and error tokens are one byte wide.
    a_tok_shape: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> ((head.kind != K_EOF) || (head.length == '0)) &&
                        ((head.kind != K_ERROR) || (head.length == LENGTH_WIDTH'(1))))
        else $error("malformed end or error token");

    // When a byte yields two tokens, only the second closes the run.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (emit.count == 2'd2)) |-> (!emit.tok0.last && emit.tok1.last))
        else $error("last-of-run flag misplaced");

endmodule

FILE: tb/tb_c_subset_lexer.sv
// Self-checking testbench for the c_subset_lexer token scanner.
// Depends on clex_pkg for the token kinds, field widths and the tok_t layout.
`timescale 1ns / 1ps

module tb_c_subset_lexer;
    import clex_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_BYTES    = 175;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX  = '1;
    localparam logic [LINE_W-1:0]       LINE_MAX = '1;

    typedef enum logic [5:0] {
        SCAN_IDLE    = 6'b000001,
        SCAN_WORD    = 6'b000010,
        SCAN_NUM     = 6'b000100,
        SCAN_SLASH   = 6'b001000,
        SCAN_COMMENT = 6'b010000,
        SCAN_OP      = 6'b100000
    } scan_t;

    // One source byte waiting to be sent. Rows of the directed table may carry
    // the token they must produce, typed in by hand.
    typedef struct {
        logic [7:0] code;
        bit         known;
        tok_t       tok;
    } src_byte_t;

    logic                      clk;
    logic                      rst_n       = 1'b0;
    logic                      char_valid  = 1'b0;
    logic                      char_stall;
    logic [7:0]                char_code   = 8'h00;
    logic                      token_valid;
    logic                      token_stall = 1'b0;
    logic [KIND_W-1:0]         token_kind;
    logic [POSITION_WIDTH-1:0] token_start;
    logic [LENGTH_WIDTH-1:0]   token_length;
    logic [LINE_W-1:0]         line_number;
    logic [VALUE_W-1:0]        token_value;
    logic                      last_of_run;

    c_subset_lexer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_code    (char_code),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .line_number  (line_number),
        .token_value  (token_value),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scanner model: its own copy of the lexer state.
    // ------------------------------------------------------------------
    scan_t                     scan_mode;
    logic [POSITION_WIDTH-1:0] scan_pos;
    logic [POSITION_WIDTH-1:0] tok_begin;
    logic [LENGTH_WIDTH-1:0]   tok_len;
    logic [LINE_W-1:0]         line_cnt;
    logic [VALUE_W-1:0]        num_acc;
    bit                        digits_over;
    logic [7:0]                word_head [KEYWORD_CHARS];
    logic [7:0]                pend_op;

    tok_t step_tokens[$];
    tok_t predicted_tokens[$];

    function void reset_scanner();
        scan_mode   = SCAN_IDLE;
        scan_pos    = '0;
        tok_begin   = '0;
        tok_len     = '0;
        line_cnt    = LINE_W'(1);
        num_acc     = '0;
        digits_over = 1'b0;
        pend_op     = 8'h00;
        for (int i = 0; i < KEYWORD_CHARS; i++)
        begin
            word_head[i] = 8'h00;
        end
    endfunction

    function bit letter_byte(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit digit_byte(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function void emit_token(kind_t k, logic [POSITION_WIDTH-1:0] s,
                             logic [LENGTH_WIDTH-1:0] l, logic [VALUE_W-1:0] v);
        tok_t t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.line   = line_cnt;
        t.value  = v;
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function void bump_pos();
        scan_pos = scan_pos + 1'b1;
    endfunction

    function void grow_len();
        if (tok_len != LEN_MAX)
        begin
            tok_len = tok_len + 1'b1;
        end
    endfunction

    // Only the first tok_len head bytes belong to the current word; the exact
    // length must match, so a saturated word can never be a keyword.
    function kind_t keyword_kind();
        logic [47:0] w;
        kind_t       k;
        w = {word_head[0], word_head[1], word_head[2],
             word_head[3], word_head[4], word_head[5]};
        k = K_IDENT;
        case (tok_len)
            16'd2: if (w[47:32] == "if")     k = K_IF;
            16'd3: if (w[47:24] == "int")    k = K_INT;
            16'd4: if (w[47:16] == "else")   k = K_ELSE;
            16'd5: if (w[47:8]  == "while")  k = K_WHILE;
            16'd6: if (w        == "return") k = K_RETURN;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

    function kind_t op_token(logic [7:0] op, bit two);
        case (op)
            "!":     return two ? K_NE : K_BANG;
            "=":     return two ? K_EQ : K_ASSIGN;
            "<":     return two ? K_LE : K_LT;
            default: return two ? K_GE : K_GT;
        endcase
    endfunction

    // A byte seen between tokens.
    function void from_idle(logic [7:0] c);
        kind_t single;
        bit    has_single;
        has_single = 1'b1;
        single     = K_EOF;
        case (c)
            CH_NUL:
            begin
                emit_token(K_EOF, scan_pos, '0, '0);
                scan_pos  = '0;
                line_cnt  = LINE_W'(1);
                scan_mode = SCAN_IDLE;
                return;
            end
            " ", CH_TAB, CH_CR:
            begin
                bump_pos();
                return;
            end
            CH_LF:
            begin
                if (line_cnt != LINE_MAX)
                begin
                    line_cnt = line_cnt + 1'b1;
                end
                bump_pos();
                return;
            end
            "/":
            begin
                tok_begin = scan_pos;
                scan_mode = SCAN_SLASH;
                bump_pos();
                return;
            end
            "!", "=", "<", ">":
            begin
                tok_begin = scan_pos;
                pend_op   = c;
                scan_mode = SCAN_OP;
                bump_pos();
                return;
            end
            "(": single = K_LPAREN;
            ")": single = K_RPAREN;
            "{": single = K_LBRACE;
            "}": single = K_RBRACE;
            ";": single = K_SEMI;
            ",": single = K_COMMA;
            "+": single = K_PLUS;
            "-": single = K_MINUS;
            "*": single = K_STAR;
            default: has_single = 1'b0;
        endcase
        if (has_single)
        begin
            emit_token(single, scan_pos, LENGTH_WIDTH'(1), '0);
            bump_pos();
            return;
        end
        if (letter_byte(c) || c == "_")
        begin
            tok_begin    = scan_pos;
            tok_len      = LENGTH_WIDTH'(1);
            word_head[0] = c;
            scan_mode    = SCAN_WORD;
            bump_pos();
            return;
        end
        if (digit_byte(c))
        begin
            tok_begin   = scan_pos;
            tok_len     = LENGTH_WIDTH'(1);
            num_acc     = VALUE_W'(c - "0");
            digits_over = 1'b0;
            scan_mode   = SCAN_NUM;
            bump_pos();
            return;
        end
        emit_token(K_ERROR, scan_pos, LENGTH_WIDTH'(1), {23'd0, c});
        bump_pos();
    endfunction

    // Scans one byte and leaves the tokens it causes in step_tokens.
    function void lex_byte(logic [7:0] c);
        int unsigned d;
        int unsigned acc;
        tok_t        t;
        step_tokens.delete();
        case (scan_mode)
            SCAN_WORD:
            begin
                if (letter_byte(c) || digit_byte(c) || c == "_")
                begin
                    if (tok_len < KEYWORD_CHARS)
                    begin
                        word_head[tok_len] = c;
                    end
                    grow_len();
                    bump_pos();
                end
                else
                begin
                    emit_token(keyword_kind(), tok_begin, tok_len, '0);
                    scan_mode = SCAN_IDLE;
                    from_idle(c);
                end
            end
            SCAN_NUM:
            begin
                if (letter_byte(c) || digit_byte(c))
                begin
                    // Only the leading run of digits feeds the value.
                    if (digit_byte(c) && !digits_over)
                    begin
                        d   = c - "0";
                        acc = num_acc;
                        if (acc > (VALUE_LIMIT - d) / 10)
                        begin
                            num_acc = VALUE_LIMIT;
                        end
                        else
                        begin
                            num_acc = VALUE_W'(acc * 10 + d);
                        end
                    end
                    else
                    begin
                        digits_over = 1'b1;
                    end
                    grow_len();
                    bump_pos();
                end
                else
                begin
                    emit_token(K_NUMBER, tok_begin, tok_len, num_acc);
                    scan_mode = SCAN_IDLE;
                    from_idle(c);
                end
            end
            SCAN_SLASH:
            begin
                if (c == "/")
                begin
                    scan_mode = SCAN_COMMENT;
                    bump_pos();
                end
                else
                begin
                    emit_token(K_SLASH, tok_begin, LENGTH_WIDTH'(1), '0);
                    scan_mode = SCAN_IDLE;
                    from_idle(c);
                end
            end
            SCAN_COMMENT:
            begin
                if (c == CH_NUL || c == CH_LF)
                begin
                    scan_mode = SCAN_IDLE;
                    from_idle(c);
                end
                else
                begin
                    bump_pos();
                end
            end
            SCAN_OP:
            begin
                if (c == "=")
                begin
                    emit_token(op_token(pend_op, 1'b1), tok_begin, LENGTH_WIDTH'(2), '0);
                    scan_mode = SCAN_IDLE;
                    bump_pos();
                end
                else
                begin
                    emit_token(op_token(pend_op, 1'b0), tok_begin, LENGTH_WIDTH'(1), '0);
                    scan_mode = SCAN_IDLE;
                    from_idle(c);
                end
            end
            default:
            begin
                scan_mode = SCAN_IDLE;
                from_idle(c);
            end
        endcase
        if (step_tokens.size() > 0)
        begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------
    // Source text and its generators.
    // ------------------------------------------------------------------
    src_byte_t src_q[$];
    src_byte_t directed_rows[$];
    src_byte_t on_port;

    int bytes_queued   = 0;
    int bytes_accepted = 0;
    int tokens_checked = 0;
    int mismatches     = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;

    function void push_byte(logic [7:0] c);
        src_byte_t b;
        b.code  = c;
        b.known = 1'b0;
        b.tok   = '0;
        src_q.push_back(b);
        bytes_queued++;
    endfunction

    function void push_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s[i]);
        end
    endfunction

    function void row_plain(logic [7:0] c);
        src_byte_t r;
        r.code  = c;
        r.known = 1'b0;
        r.tok   = '0;
        directed_rows.push_back(r);
    endfunction

    function void row_known(logic [7:0] c, kind_t k, int s, int l, int ln, int v);
        src_byte_t r;
        tok_t      t;
        t.kind   = k;
        t.start  = POSITION_WIDTH'(s);
        t.length = LENGTH_WIDTH'(l);
        t.line   = LINE_W'(ln);
        t.value  = VALUE_W'(v);
        t.last   = 1'b1;
        r.code   = c;
        r.known  = 1'b1;
        r.tok    = t;
        directed_rows.push_back(r);
    endfunction

    function string pick_keyword();
        case ($urandom_range(4))
            0:       return "if";
            1:       return "else";
            2:       return "int";
            3:       return "while";
            default: return "return";
        endcase
    endfunction

    // A byte that may begin (first set) or continue a word.
    function logic [7:0] word_char(bit first);
        int r;
        r = $urandom_range(first ? 52 : 62);
        if (r < 26)
        begin
            return 8'("a" + r);
        end
        if (r < 52)
        begin
            return 8'("A" + (r - 26));
        end
        if (r == 52)
        begin
            return "_";
        end
        return 8'("0" + (r - 53));
    endfunction

    // Appends one lexeme of random content; most are well formed, a few are
    // stray bytes and early ends of text.
    function void add_random_lexeme();
        int    pick;
        int    n;
        bit    spaced;
        string kw;
        string ops;
        pick   = $urandom_range(99);
        spaced = 1'b0;
        if (pick < 10)
        begin
            push_text(pick_keyword());
            spaced = 1'b1;
        end
        else if (pick < 25)
        begin
            kw = pick_keyword();
            case ($urandom_range(3))
                1:
                begin
                    push_text(kw);
                    push_byte(word_char(1'b0));
                end
                2: push_text(kw.substr(0, kw.len() - 2));
                3:
                begin
                    push_byte(kw[0] - 8'd32);
                    push_text(kw.substr(1, kw.len() - 1));
                end
                default:
                begin
                    n = $urandom_range(1, 8);
                    push_byte(word_char(1'b1));
                    for (int i = 1; i < n; i++)
                    begin
                        push_byte(word_char(1'b0));
                    end
                end
            endcase
            spaced = 1'b1;
        end
        else if (pick < 37)
        begin
            case ($urandom_range(19))
                0: push_text("2147483647");
                1: push_text("2147483648");
                2: push_text("4294967296");
                default:
                begin
                    n = $urandom_range(1, 12);
                    for (int i = 0; i < n; i++)
                    begin
                        push_byte(8'("0" + $urandom_range(9)));
                    end
                end
            endcase
            // Letters after the digits stay part of the number.
            if ($urandom_range(4) == 0)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                begin
                    push_byte(word_char(1'b0));
                end
            end
            spaced = 1'b1;
        end
        else if (pick < 52)
        begin
            ops = "(){};,+-*/";
            push_byte(ops[$urandom_range(9)]);
        end
        else if (pick < 64)
        begin
            ops = "!=<>";
            push_byte(ops[$urandom_range(3)]);
            if ($urandom_range(1) == 0)
            begin
                push_byte("=");
            end
        end
        else if (pick < 78)
        begin
            case ($urandom_range(2))
                0:       push_byte(" ");
                1:       push_byte(CH_TAB);
                default: push_byte(CH_CR);
            endcase
        end
        else if (pick < 83)
        begin
            push_byte(CH_LF);
        end
        else if (pick < 88)
        begin
            push_text("//");
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
            begin
                push_byte(8'($urandom_range(32, 126)));
            end
            push_byte(($urandom_range(9) == 0) ? CH_NUL : CH_LF);
        end
        else if (pick < 96)
        begin
            push_byte(8'(($urandom_range(1) == 0) ? $urandom_range(128, 255)
                                                  : $urandom_range(255)));
        end
        else
        begin
            push_byte(CH_NUL);
        end
        if (spaced && $urandom_range(9) < 7)
        begin
            push_byte(($urandom_range(3) == 0) ? CH_LF : " ");
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte sender: holds the item while stalled, idles at random otherwise.
    // The model sees each byte at the edge where it is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && !char_stall)
            begin
                lex_byte(on_port.code);
                if (on_port.known)
                begin
                    predicted_tokens.push_back(on_port.tok);
                end
                else
                begin
                    foreach (step_tokens[i])
                    begin
                        predicted_tokens.push_back(step_tokens[i]);
                    end
                end
                bytes_accepted++;
            end
            if (char_valid && char_stall)
            begin
                // The stalled item stays on the port unchanged.
            end
            else if (src_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                on_port = src_q.pop_front();
                char_valid <= 1'b1;
                char_code  <= on_port.code;
            end
            else
            begin
                char_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Token receiver and checker.
    // ------------------------------------------------------------------
    function void check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: token %0d %s mismatch: expected %0d, actual %0d",
                     $time, tokens_checked, name, want, got);
        end
    endfunction

    function void check_token(tok_t want);
        check_field("kind",   want.kind,   token_kind);
        check_field("start",  want.start,  token_start);
        check_field("length", want.length, token_length);
        check_field("line",   want.line,   line_number);
        check_field("value",  want.value,  token_value);
        check_field("last",   want.last,   last_of_run);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (token_valid && !token_stall)
            begin
                if (predicted_tokens.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected token: expected none, actual kind %0d start %0d",
                             $time, token_kind, token_start);
                end
                else
                begin
                    check_token(predicted_tokens.pop_front());
                end
                tokens_checked++;
            end
            token_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial
    begin
        int quiet;
        int seen_in;
        int seen_out;
        quiet    = 0;
        seen_in  = 0;
        seen_out = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (bytes_accepted != seen_in || tokens_checked != seen_out)
            begin
                seen_in  = bytes_accepted;
                seen_out = tokens_checked;
                quiet    = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t ns: no item moved for %0d cycles, %0d tokens still expected",
                 $time, WATCHDOG_LIMIT, predicted_tokens.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int start_count;
        reset_scanner();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed text: "(" two high bytes, newline, "if ", "9a7" (number
        // with letters), lone bang before a word, "<=", a comment, slash
        // closed by a star, comma, then a comment cut off by the end of text.
        row_known("(",    K_LPAREN, 0, 1, 1, 0);
        row_known(8'hFF,  K_ERROR,  1, 1, 1, 255);
        row_known(8'h80,  K_ERROR,  2, 1, 1, 128);
        row_plain(CH_LF);
        row_plain("i");
        row_plain("f");
        row_plain(" ");
        row_plain("9");
        row_plain("a");
        row_plain("7");
        row_plain("!");
        row_plain("x");
        row_plain("<");
        row_plain("=");
        row_plain("/");
        row_plain("/");
        row_plain("c");
        row_plain(CH_LF);
        row_plain("/");
        row_plain("*");
        row_known(",",    K_COMMA,  20, 1, 3, 0);
        row_plain("/");
        row_plain("/");
        row_known(CH_NUL, K_EOF,    23, 0, 3, 0);
        foreach (directed_rows[i])
        begin
            src_q.push_back(directed_rows[i]);
            bytes_queued++;
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 70;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 70;
                end
                default:
                begin
                    send_idle_pct = 17;
                    stall_pct     = 17;
                end
            endcase
            start_count = bytes_queued;
            while (bytes_queued - start_count < PHASE_BYTES)
            begin
                add_random_lexeme();
            end
            push_byte(CH_NUL);
            while (bytes_accepted < bytes_queued)
            begin
                @(posedge clk);
            end
        end

        while (predicted_tokens.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d source bytes: a directed table, then four idle/stall mixes.",
                 bytes_accepted);
        $display("Checked %0d tokens field by field, %0d mismatches.",
                 tokens_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
